// File: rtl/tcbp_pkg.sv
// Shared types and constants of the tree code bit packer.
package tcbp_pkg;

  // Bits in one packed output byte.
  localparam int BYTE_BITS = 8;
  // Width of a node index on the input channel and in the stores.
  localparam int NODE_W = 9;
  // Longest walk in bits; it bounds the results of one encode item.
  localparam int WALK_LIMIT = 256;
  // Width of the walk step counter, which must hold WALK_LIMIT itself.
  localparam int STEP_W = $clog2(WALK_LIMIT + 1);
  // Width of the held bit count, which must hold BYTE_BITS itself.
  localparam int COUNT_W = $clog2(BYTE_BITS + 1);

  // Input commands.
  typedef enum logic [1:0] {
    CMD_NODE   = 2'd0,
    CMD_LEAF   = 2'd1,
    CMD_ENCODE = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  // One node store entry; the packed layout matches the stored 11-bit word.
  typedef struct packed {
    logic              is_right;
    logic              has_parent;
    logic [NODE_W-1:0] parent;
  } node_entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAF,
    S_STEP,
    S_FLUSH_HEAD,
    S_FLUSH_TAIL
  } state_t;

endpackage

// File: rtl/tcbp_in_if.sv
// Input channel of the tree code bit packer: valid, ready and one command item.
interface tcbp_in_if;
  import tcbp_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [NODE_W-1:0] node_index;
  logic [NODE_W-1:0] parent_index;
  logic              has_parent;
  logic              is_right;
  logic [7:0]        symbol;

  modport source (
    output valid, command, node_index, parent_index, has_parent, is_right, symbol,
    input  ready
  );

  modport sink (
    input  valid, command, node_index, parent_index, has_parent, is_right, symbol,
    output ready
  );
endinterface

// File: rtl/tcbp_out_if.sv
// Output channel of the tree code bit packer: valid, ready and one result item.
interface tcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic [3:0] pad_bits;
  logic       is_final;
  logic       last;

  modport source (
    output valid, packed_byte, pad_bits, is_final, last,
    input  ready
  );

  modport sink (
    input  valid, packed_byte, pad_bits, is_final, last,
    output ready
  );
endinterface

// File: rtl/tree_code_bit_packer.sv
// Top level of the tree code bit packer: tree stores, walk sequencer and byte packer.
//
// The block holds a code tree in a node RAM (parent link, has-parent flag and
// right-child mark per node) and a leaf map RAM (leaf node per symbol). An
// encode item is accepted, its leaf is looked up in the leaf map, and then it
// walks from the leaf to the root, one code bit per node; the registered read
// data of the node RAM directly addresses the next read. The walk ends at the
// root or at the walk limit, and the input is not ready again before it ends. A
// flush is accepted, then transfers the held byte and then a final result with
// the pad bit count. A completed byte leaves only when a further bit arrives,
// and the last byte of an encode item leaves with last set when its walk ends;
// a sequencer step that needs the output register waits while an earlier
// result has not been taken. Store entries are undefined until written and
// need no clearing after reset. The input is ready only between items.
module tree_code_bit_packer #(
  parameter int MAX_NODES = 512,
  parameter int SYMBOLS   = 256
) (
  input  logic          clk,
  input  logic          rst,
  tcbp_in_if.sink       in_ch,
  tcbp_out_if.source    out_ch
);
  import tcbp_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int LAW = $clog2(SYMBOLS);

  state_t               state, state_next;
  logic [NODE_W-1:0]    node, node_next;
  logic [STEP_W-1:0]    steps, steps_next;
  logic [7:0]           held_byte, held_byte_next;
  logic [COUNT_W-1:0]   held_count, held_count_next;
  logic                 pend_valid, pend_valid_next;
  logic [7:0]           pend_byte, pend_byte_next;

  logic                 out_valid;
  logic [7:0]           out_byte;
  logic [3:0]           out_pad;
  logic                 out_final;
  logic                 out_last;
  logic                 out_load;
  logic [7:0]           load_byte;
  logic [3:0]           load_pad;
  logic                 load_final;
  logic                 load_last;
  logic                 out_free;

  logic                 node_we;
  logic [NAW-1:0]       node_raddr;
  logic [NODE_W+1:0]    node_rdata;
  logic                 leaf_we;
  logic [LAW-1:0]       leaf_raddr;
  logic [NODE_W-1:0]    leaf_rdata;

  node_entry_t          wr_entry;
  node_entry_t          entry;
  logic                 node_in_range;
  logic                 walk_done;
  logic                 byte_full;
  logic                 blocked;

  // Tree stores.
  assign wr_entry = '{is_right: in_ch.is_right, has_parent: in_ch.has_parent,
                      parent: in_ch.parent_index};

  tcbp_ram #(.WIDTH(NODE_W + 2), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (NAW'(in_ch.node_index)),
    .wdata (wr_entry),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  tcbp_ram #(.WIDTH(NODE_W), .DEPTH(SYMBOLS)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (LAW'(in_ch.symbol)),
    .wdata (in_ch.node_index),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  // Walk conditions for the node whose entry is on the read port.
  assign entry         = node_entry_t'(node_rdata);
  assign node_in_range = (32'(node) < MAX_NODES);
  assign walk_done     = !node_in_range || (steps == STEP_W'(WALK_LIMIT)) ||
                         !entry.has_parent;
  assign byte_full     = (held_count == COUNT_W'(BYTE_BITS));
  assign blocked       = byte_full && pend_valid && !out_free;
  assign out_free      = !out_valid || out_ch.ready;

  assign in_ch.ready   = (state == S_IDLE);

  // Sequencer state and data registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_byte  <= '0;
      held_count <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      held_byte  <= held_byte_next;
      held_count <= held_count_next;
      pend_valid <= pend_valid_next;
    end
    node      <= node_next;
    steps     <= steps_next;
    pend_byte <= pend_byte_next;
  end

  // Next state, store accesses and output loads.
  always_comb begin
    state_next      = state;
    node_next       = node;
    steps_next      = steps;
    held_byte_next  = held_byte;
    held_count_next = held_count;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    out_load        = 1'b0;
    load_byte       = '0;
    load_pad        = '0;
    load_final      = 1'b0;
    load_last       = 1'b0;
    node_we         = 1'b0;
    leaf_we         = 1'b0;
    node_raddr      = NAW'(node);
    leaf_raddr      = LAW'(in_ch.symbol);

    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.command)
            CMD_NODE:   node_we = (32'(in_ch.node_index) < MAX_NODES);
            CMD_LEAF:   leaf_we = (32'(in_ch.symbol) < SYMBOLS);
            CMD_ENCODE: begin
              if (32'(in_ch.symbol) < SYMBOLS) begin
                state_next = S_LEAF;
              end
            end
            CMD_FLUSH:  state_next = S_FLUSH_HEAD;
            default:    state_next = S_IDLE;
          endcase
        end
      end

      // The leaf node arrives and addresses the first node read.
      S_LEAF: begin
        node_next  = leaf_rdata;
        steps_next = '0;
        node_raddr = NAW'(leaf_rdata);
        state_next = S_STEP;
      end

      // One code bit per cycle while the output is not blocked; a full byte waits in the pending slot.
      S_STEP: begin
        if (walk_done) begin
          if (!pend_valid) begin
            state_next = S_IDLE;
          end else if (out_free) begin
            out_load        = 1'b1;
            load_byte       = pend_byte;
            load_last       = 1'b1;
            pend_valid_next = 1'b0;
            state_next      = S_IDLE;
          end
        end else if (!blocked) begin
          if (byte_full) begin
            if (pend_valid) begin
              out_load  = 1'b1;
              load_byte = pend_byte;
            end
            pend_byte_next  = held_byte;
            pend_valid_next = 1'b1;
            held_byte_next  = {7'b0, entry.is_right};
            held_count_next = COUNT_W'(1);
          end else begin
            held_byte_next  = {held_byte[6:0], entry.is_right};
            held_count_next = held_count + COUNT_W'(1);
          end
          node_next  = entry.parent;
          steps_next = steps + STEP_W'(1);
          node_raddr = NAW'(entry.parent);
        end
      end

      S_FLUSH_HEAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_byte  = held_byte;
          state_next = S_FLUSH_TAIL;
        end
      end

      S_FLUSH_TAIL: begin
        if (out_free) begin
          out_load        = 1'b1;
          load_pad        = 4'(BYTE_BITS) - 4'(held_count);
          load_final      = 1'b1;
          load_last       = 1'b1;
          held_byte_next  = '0;
          held_count_next = '0;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Output register; it frees when its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_byte  <= load_byte;
      out_pad   <= load_pad;
      out_final <= load_final;
      out_last  <= load_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.packed_byte = out_byte;
  assign out_ch.pad_bits    = out_pad;
  assign out_ch.is_final    = out_final;
  assign out_ch.last        = out_last;

  // A pending byte exists only inside a walk.
  assert property (@(posedge clk) disable iff (rst) pend_valid |-> state == S_STEP)
    else $error("pending byte outside a walk");

  // The packer never holds more than one byte of bits.
  assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(BYTE_BITS))
    else $error("held bit count above a byte");

  // The padding result always closes its item.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_final |-> out_ch.last)
    else $error("final result without last");

  // A finished flush leaves the packer empty.
  assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH_TAIL && out_load |=> held_count == '0 && held_byte == '0)
    else $error("packer not cleared by flush");

endmodule

// File: rtl/tcbp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
